@@ hw/rtl/ssym_pkg.sv @@
// Shared types and constants of the scoped symbol table.
// Item kinds, result codes, controller states and the control/status bundles.
// No dependencies.
`timescale 1ns / 1ps

package ssym_pkg;

	localparam int KIND_W     = 3;
	localparam int KEY_W      = 64;
	localparam int SCOPE_W    = 8;
	localparam int STATUS_W   = 3;
	localparam int INDEX_W    = 8;
	localparam int TOTAL_W    = 9;
	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 32;

	typedef enum logic [KIND_W-1:0] {
		K_DECLARE = 3'd0,
		K_ENTER   = 3'd1,
		K_LEAVE   = 3'd2,
		K_LOOKUP  = 3'd3,
		K_DROP    = 3'd4,
		K_CLEAR   = 3'd5
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_NOT_FOUND = 3'd1,
		ST_FULL      = 3'd2,
		ST_EMPTY     = 3'd3,
		ST_SCOPE     = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_RESULT
	} state_t;

	typedef struct packed {
		logic load;
		logic exec_simple;
		logic scan_start;
		logic scan_step;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic scan_needed;
		logic scan_done;
		logic out_free;
	} sts_t;

endpackage

@@ hw/rtl/ssym_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ssym_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hw/rtl/ssym_ctrl.sv @@
// Controller state machine of the scoped symbol table.
// Sequences load, execute, table scan and result hand-off; uses ssym_pkg.
`timescale 1ns / 1ps

module ssym_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  ssym_pkg::sts_t sts,
	output ssym_pkg::cmd_t cmd
);

	import ssym_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) state_d = S_EXEC;
			end
			S_EXEC: begin
				state_d = sts.scan_needed ? S_SCAN : S_RESULT;
			end
			S_SCAN: begin
				if (sts.scan_done) state_d = S_RESULT;
			end
			S_RESULT: begin
				if (sts.out_free) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready        = 1'b0;
		cmd             = '0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			S_EXEC: begin
				cmd.exec_simple = !sts.scan_needed;
				cmd.scan_start  = sts.scan_needed;
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
			end
			S_RESULT: begin
				cmd.emit = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

@@ hw/rtl/ssym_dp.sv @@
// Datapath of the scoped symbol table: entry RAM, fill count, scope level,
// scan pointer, result and output registers. Uses ssym_pkg and ssym_ram.
`timescale 1ns / 1ps

module ssym_dp #(
	parameter int TABLE_ENTRIES = 256,
	parameter int NAME_BYTES    = 8,
	parameter int MAX_SCOPE     = 255
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ssym_pkg::cmd_t                 cmd,
	output ssym_pkg::sts_t                 sts,
	input  logic [ssym_pkg::IN_DATA_W-1:0] s_tdata,
	input  logic [ssym_pkg::KIND_W-1:0]    s_tuser,
	input  logic                           m_tready,
	output logic                           m_tvalid,
	output logic [ssym_pkg::OUT_DATA_W-1:0] m_tdata
);

	import ssym_pkg::*;

	localparam int IW    = $clog2(TABLE_ENTRIES);
	localparam int FW    = $clog2(TABLE_ENTRIES + 1);
	localparam int MEM_W = KEY_W + 1 + SCOPE_W;
	localparam int PAD_W = OUT_DATA_W - STATUS_W - INDEX_W - 1 - TOTAL_W - SCOPE_W;

	function automatic logic [KEY_W-1:0] name_key(input logic [KEY_W-1:0] raw);
		logic [KEY_W-1:0] key;
		logic             live;
		key  = '0;
		live = 1'b1;
		for (int b = 0; b < KEY_W / 8; b++) begin
			if (b >= NAME_BYTES || raw[8*b +: 8] == 8'h00) live = 1'b0;
			if (live) key[8*b +: 8] = raw[8*b +: 8];
		end
		return key;
	endfunction

	kind_t              kind_q;
	logic [KEY_W-1:0]   key_q;
	logic               init_q;
	logic [FW-1:0]      fill_q;
	logic [SCOPE_W-1:0] scope_q;
	logic [IW-1:0]      rd_idx_s1;
	status_t            res_status_q;
	logic [IW-1:0]      res_index_q;
	logic               res_flag_q;
	logic               out_vld_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	logic [FW-1:0]      fill_d;
	logic [SCOPE_W-1:0] scope_d;
	status_t            res_status_d;
	logic [IW-1:0]      res_index_d;
	logic               res_flag_d;

	logic               mem_we;
	logic               mem_re;
	logic [IW-1:0]      mem_raddr;
	logic [MEM_W-1:0]   mem_wdata;
	logic [MEM_W-1:0]   mem_rdata;

	logic [KEY_W-1:0]   rd_key;
	logic               rd_flag;
	logic [SCOPE_W-1:0] rd_scope;
	logic [FW-1:0]      fill_m1;
	logic [IW-1:0]      idx_m1;
	logic               full;
	logic               hit;
	logic               pop;
	logic               last;
	logic [IW+INDEX_W-1:0] idx_ext;
	logic [FW+TOTAL_W-1:0] total_ext;

	assign rd_key   = mem_rdata[KEY_W-1:0];
	assign rd_flag  = mem_rdata[KEY_W];
	assign rd_scope = mem_rdata[MEM_W-1 -: SCOPE_W];
	assign fill_m1  = fill_q - FW'(1);
	assign idx_m1   = rd_idx_s1 - IW'(1);
	assign full     = fill_q >= FW'(TABLE_ENTRIES);
	assign hit      = rd_key == key_q;
	assign pop      = rd_scope > scope_q;
	assign last     = rd_idx_s1 == '0;

	assign sts.scan_needed = (fill_q != '0) &&
		(kind_q == K_LOOKUP || (kind_q == K_LEAVE && scope_q != '0));
	assign sts.scan_done   = (kind_q == K_LOOKUP) ? (hit || last) : (!pop || last);
	assign sts.out_free    = !out_vld_q || m_tready;

	assign mem_we    = cmd.exec_simple && kind_q == K_DECLARE && !full;
	assign mem_wdata = {scope_q, init_q, key_q};
	assign mem_re    = cmd.scan_start || (cmd.scan_step && !sts.scan_done);
	assign mem_raddr = cmd.scan_start ? fill_m1[IW-1:0] : idx_m1;

	ssym_ram #(
		.WIDTH(MEM_W),
		.DEPTH(TABLE_ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(fill_q[IW-1:0]),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	always_comb begin
		fill_d       = fill_q;
		scope_d      = scope_q;
		res_status_d = res_status_q;
		res_index_d  = res_index_q;
		res_flag_d   = res_flag_q;
		if (cmd.exec_simple) begin
			res_status_d = ST_OK;
			res_index_d  = '0;
			res_flag_d   = 1'b0;
			case (kind_q)
				K_DECLARE: begin
					if (full) begin
						res_status_d = ST_FULL;
					end else begin
						res_index_d = fill_q[IW-1:0];
						fill_d      = fill_q + FW'(1);
					end
				end
				K_ENTER: begin
					if (scope_q >= SCOPE_W'(MAX_SCOPE)) res_status_d = ST_SCOPE;
					else scope_d = scope_q + SCOPE_W'(1);
				end
				K_LEAVE: begin
					if (scope_q == '0) res_status_d = ST_SCOPE;
					else scope_d = scope_q - SCOPE_W'(1);
				end
				K_LOOKUP: begin
					res_status_d = ST_NOT_FOUND;
				end
				K_DROP: begin
					if (fill_q == '0) res_status_d = ST_EMPTY;
					else fill_d = fill_m1;
				end
				K_CLEAR: begin
					fill_d = '0;
				end
				default: begin
					res_status_d = ST_OK;
				end
			endcase
		end else if (cmd.scan_start) begin
			res_status_d = ST_OK;
			res_index_d  = '0;
			res_flag_d   = 1'b0;
			if (kind_q == K_LEAVE) scope_d = scope_q - SCOPE_W'(1);
		end else if (cmd.scan_step) begin
			if (kind_q == K_LOOKUP) begin
				if (hit) begin
					res_index_d = rd_idx_s1;
					res_flag_d  = rd_flag;
				end else if (last) begin
					res_status_d = ST_NOT_FOUND;
				end
			end else if (pop) begin
				fill_d = fill_m1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			scope_q   <= '0;
			out_vld_q <= 1'b0;
		end else begin
			fill_q  <= fill_d;
			scope_q <= scope_d;
			if (cmd.emit) out_vld_q <= 1'b1;
			else if (m_tready) out_vld_q <= 1'b0;
		end
	end

	assign idx_ext   = {{INDEX_W{1'b0}}, res_index_q};
	assign total_ext = {{TOTAL_W{1'b0}}, fill_q};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind_t'(s_tuser);
			key_q  <= name_key(s_tdata[KEY_W-1:0]);
			init_q <= s_tdata[KEY_W];
		end
		if (mem_re) rd_idx_s1 <= mem_raddr;
		res_status_q <= res_status_d;
		res_index_q  <= res_index_d;
		res_flag_q   <= res_flag_d;
		if (cmd.emit) begin
			out_data_q <= {{PAD_W{1'b0}}, scope_q, total_ext[TOTAL_W-1:0], res_flag_q,
				idx_ext[INDEX_W-1:0], res_status_q};
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;

endmodule

@@ hw/rtl/scoped_symbol_table.sv @@
// Scoped symbol table: a stack of named entries with scope levels.
// Per item: load on the input transfer, execute, then a table scan when a lookup or scope
// exit needs one (up to TABLE_ENTRIES entries, one RAM read per cycle), then the result.
// One item is in work at a time; the next input transfer is
// taken while a result still waits in the output register.
// Reset (arst_n, asynchronous): clears fill count, scope level, controller, output valid.
`timescale 1ns / 1ps

module scoped_symbol_table #(
	parameter int TABLE_ENTRIES = 256,
	parameter int NAME_BYTES    = 8,
	parameter int MAX_SCOPE     = 255
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [ssym_pkg::IN_DATA_W-1:0]  s_tdata,  // sym_name[63:0], sym_init[64], zero
	input  logic [ssym_pkg::KIND_W-1:0]     s_tuser,  // kind[2:0]
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [ssym_pkg::OUT_DATA_W-1:0] m_tdata   // status[2:0], entry_index[10:3],
	                                                  // found_init[11], entry_total[20:12],
	                                                  // scope_now[28:21], zero
);

	import ssym_pkg::*;

	cmd_t cmd;
	sts_t sts;

	ssym_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	ssym_dp #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.NAME_BYTES   (NAME_BYTES),
		.MAX_SCOPE    (MAX_SCOPE)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.sts     (sts),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tready(m_tready),
		.m_tvalid(m_tvalid),
		.m_tdata (m_tdata)
	);

endmodule

@@ hw/rtl/ssym_chk.sv @@
// Port-level checker of the scoped symbol table, bound to the top level.
// Uses ssym_pkg.
`timescale 1ns / 1ps

module ssym_chk #(
	parameter int TABLE_ENTRIES = 256,
	parameter int MAX_SCOPE     = 255
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [ssym_pkg::OUT_DATA_W-1:0] m_tdata
);

	import ssym_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output transfer changed while stalled");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an item is in work");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2:0] == ST_NOT_FOUND |-> m_tdata[11:3] == 9'd0)
		else $error("miss carries an index or flag");

	a_full_total: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2:0] == ST_FULL |-> m_tdata[20:12] == TOTAL_W'(TABLE_ENTRIES))
		else $error("full reported below capacity");

	a_scope_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[28:21] <= SCOPE_W'(MAX_SCOPE))
		else $error("scope level beyond limit");

endmodule

bind scoped_symbol_table ssym_chk #(
	.TABLE_ENTRIES(TABLE_ENTRIES),
	.MAX_SCOPE    (MAX_SCOPE)
) u_ssym_chk (.*);
